[src/mf3_pkg.sv]
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared types and constants for the streaming 3x3 median filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

   localparam int PIXEL_BITS     = 8;
   localparam int SIZE_BITS      = 11;
   localparam int COORD_BITS     = 10;
   localparam int CSR_INDEX_BITS = 4;
   localparam int WIN_TAPS       = 9;
   localparam int TAP_BITS       = 4;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 4'd1;

   localparam logic [SIZE_BITS-1:0] RESET_WIDTH  = 11'd640;
   localparam logic [SIZE_BITS-1:0] RESET_HEIGHT = 11'd480;
   localparam logic [SIZE_BITS-1:0] MIN_SIZE     = 11'd3;
   localparam logic [SIZE_BITS-1:0] HEIGHT_CAP   = 11'd1024;
   localparam int                   SIZE_CAP     = 1024;

   // result queue
   localparam int FIFO_DEPTH      = 8;
   localparam int FIFO_PTR_BITS   = 3;
   localparam int FIFO_COUNT_BITS = 4;

   typedef logic [PIXEL_BITS-1:0] pixel_type;

   // taps 0..2 top row, 3..5 middle row, 6..8 bottom row, left to right
   typedef logic [WIN_TAPS-1:0][PIXEL_BITS-1:0] win_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel_in;
      logic                  frame_start;
   } req_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] median_value;
      logic [COORD_BITS-1:0] centre_col;
      logic [COORD_BITS-1:0] centre_row;
      logic                  frame_last;
   } rsp_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] centre_col;
      logic [COORD_BITS-1:0] centre_row;
      logic                  frame_last;
   } meta_type;

   typedef struct packed {
      logic sort_busy;
      logic pick_busy;
   } med_status_type;

endpackage

[src/mf3_median.sv]
// ----------------------------------------------------------------------------
// mf3_median
// Two-stage pipelined 19 compare-swap median-of-nine network.
// ----------------------------------------------------------------------------
module mf3_median (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  mf3_pkg::win_type       in_window,
   input  mf3_pkg::meta_type      in_meta,
   output logic                   out_valid,
   output mf3_pkg::pixel_type     out_median,
   output mf3_pkg::meta_type      out_meta,
   output mf3_pkg::med_status_type status
);

   function automatic mf3_pkg::win_type cmp_swap(
      input mf3_pkg::win_type             v,
      input logic [mf3_pkg::TAP_BITS-1:0] a,
      input logic [mf3_pkg::TAP_BITS-1:0] b
   );
      mf3_pkg::win_type r;
      r = v;
      if (v[a] > v[b]) begin
         r[a] = v[b];
         r[b] = v[a];
      end
      return r;
   endfunction

   // row sorts: three passes over each row of three
   function automatic mf3_pkg::win_type sort_rows(input mf3_pkg::win_type w);
      mf3_pkg::win_type v;
      v = w;
      v = cmp_swap(v, 4'd1, 4'd2); v = cmp_swap(v, 4'd4, 4'd5); v = cmp_swap(v, 4'd7, 4'd8);
      v = cmp_swap(v, 4'd0, 4'd1); v = cmp_swap(v, 4'd3, 4'd4); v = cmp_swap(v, 4'd6, 4'd7);
      v = cmp_swap(v, 4'd1, 4'd2); v = cmp_swap(v, 4'd4, 4'd5); v = cmp_swap(v, 4'd7, 4'd8);
      return v;
   endfunction

   // column merges and final pick of the middle tap
   function automatic mf3_pkg::pixel_type pick_median(input mf3_pkg::win_type w);
      mf3_pkg::win_type v;
      v = w;
      v = cmp_swap(v, 4'd0, 4'd3); v = cmp_swap(v, 4'd5, 4'd8); v = cmp_swap(v, 4'd4, 4'd7);
      v = cmp_swap(v, 4'd3, 4'd6); v = cmp_swap(v, 4'd1, 4'd4); v = cmp_swap(v, 4'd2, 4'd5);
      v = cmp_swap(v, 4'd4, 4'd7); v = cmp_swap(v, 4'd4, 4'd2); v = cmp_swap(v, 4'd6, 4'd4);
      v = cmp_swap(v, 4'd4, 4'd2);
      return v[4];
   endfunction

   logic               s1_valid_ff;
   mf3_pkg::win_type   s1_win_ff;
   mf3_pkg::meta_type  s1_meta_ff;
   logic               s2_valid_ff;
   mf3_pkg::pixel_type s2_median_ff;
   mf3_pkg::meta_type  s2_meta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_win_ff    <= sort_rows(in_window);
      s1_meta_ff   <= in_meta;
      s2_median_ff <= pick_median(s1_win_ff);
      s2_meta_ff   <= s1_meta_ff;
   end

   assign out_valid        = s2_valid_ff;
   assign out_median       = s2_median_ff;
   assign out_meta         = s2_meta_ff;
   assign status.sort_busy = s1_valid_ff;
   assign status.pick_busy = s2_valid_ff;

endmodule

[src/median_filter_3x3_stream.sv]
// ----------------------------------------------------------------------------
// median_filter_3x3_stream
// Streaming 3x3 median filter over 8-bit grey pixels in raster order.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while req_ready is high and returns one median beat
// per interior pixel (row and column both 2 or more); border pixels give no beat.
// The two line buffers are single-port-style memories with one read and one write
// per cycle: a pixel reads both at its column when it is accepted and writes them
// back in the next cycle, with forwarding when the next pixel hits the same column.
// A median beat passes the line buffer stage and the median stages before it is
// queued, and then shows on rsp. An eight-beat result queue decouples the sides;
// req_ready drops only when in-flight plus queued beats reach eight.
// The line buffers need no clearing pass after reset.

module median_filter_3x3_stream #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  mf3_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output mf3_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mf3_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [mf3_pkg::SIZE_BITS-1:0]        csr_wdata
);

   localparam int WIDTH_CAP = (MAX_WIDTH < mf3_pkg::SIZE_CAP) ? MAX_WIDTH : mf3_pkg::SIZE_CAP;
   localparam int ADDR_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   localparam int SB = mf3_pkg::SIZE_BITS;
   localparam int CB = mf3_pkg::COORD_BITS;

   // ---------------- configuration ----------------
   logic [SB-1:0] width_ff, width_in;
   logic [SB-1:0] height_ff, height_in;
   logic [SB-1:0] width_clamp, height_clamp;
   logic          csr_fire;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   always_comb begin
      priority if (csr_wdata < mf3_pkg::MIN_SIZE) width_clamp = mf3_pkg::MIN_SIZE;
      else if (csr_wdata > SB'(WIDTH_CAP))         width_clamp = SB'(WIDTH_CAP);
      else                                         width_clamp = csr_wdata;

      priority if (csr_wdata < mf3_pkg::MIN_SIZE) height_clamp = mf3_pkg::MIN_SIZE;
      else if (csr_wdata > mf3_pkg::HEIGHT_CAP)    height_clamp = mf3_pkg::HEIGHT_CAP;
      else                                         height_clamp = csr_wdata;

      width_in  = width_ff;
      height_in = height_ff;
      if (csr_fire) begin
         if (csr_index == mf3_pkg::CSR_FRAME_WIDTH)  width_in  = width_clamp;
         if (csr_index == mf3_pkg::CSR_FRAME_HEIGHT) height_in = height_clamp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= mf3_pkg::RESET_WIDTH;
         height_ff <= mf3_pkg::RESET_HEIGHT;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // ---------------- accept and position ----------------
   logic          req_fire;
   logic [CB-1:0] col_ff, col_in, row_ff, row_in;
   logic [CB-1:0] cur_col, cur_row;
   logic [SB-1:0] col_inc, row_inc;
   logic          row_end, frame_end, out_en, in_range;
   logic [ADDR_BITS-1:0] rd_addr;

   assign req_fire = req_valid && req_ready;

   always_comb begin
      cur_col   = req_data.frame_start ? '0 : col_ff;
      cur_row   = req_data.frame_start ? '0 : row_ff;
      col_inc   = SB'(cur_col) + SB'(1);
      row_inc   = SB'(cur_row) + SB'(1);
      row_end   = (col_inc >= width_ff);
      frame_end = row_end && (row_inc >= height_ff);
      out_en    = (cur_col[CB-1:1] != '0) && (cur_row[CB-1:1] != '0);
      in_range  = (32'(cur_col) < MAX_WIDTH);
      rd_addr   = ADDR_BITS'(cur_col);

      col_in = col_ff;
      row_in = row_ff;
      if (req_fire) begin
         if (row_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : row_inc[CB-1:0];
         end else begin
            col_in = col_inc[CB-1:0];
            row_in = cur_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------- line buffer stage ----------------
   logic               p1_valid_ff;
   logic               p1_in_range_ff;
   logic               p1_out_en_ff;
   logic               p1_fwd_ff;
   logic [CB-1:0]      p1_col_ff;
   mf3_pkg::pixel_type p1_pix_ff;
   mf3_pkg::meta_type  p1_meta_ff;
   mf3_pkg::pixel_type fwd_top_ff, fwd_mid_ff;
   mf3_pkg::pixel_type upper_rd_ff, middle_rd_ff;
   mf3_pkg::pixel_type eff_top, eff_mid;
   mf3_pkg::meta_type  meta_in;
   logic               fwd_hit;

   mf3_pkg::pixel_type upper_mem  [MAX_WIDTH];
   mf3_pkg::pixel_type middle_mem [MAX_WIDTH];

   always_comb begin
      meta_in.centre_col = cur_col - CB'(1);
      meta_in.centre_row = cur_row - CB'(1);
      meta_in.frame_last = frame_end;

      // write-back of the beat in flight lands on the same edge as this read
      fwd_hit = p1_valid_ff && p1_in_range_ff && in_range && (p1_col_ff == cur_col);

      if (!p1_in_range_ff) begin
         eff_top = '0;
         eff_mid = '0;
      end else if (p1_fwd_ff) begin
         eff_top = fwd_top_ff;
         eff_mid = fwd_mid_ff;
      end else begin
         eff_top = upper_rd_ff;
         eff_mid = middle_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && in_range) upper_rd_ff <= upper_mem[rd_addr];
      if (p1_valid_ff && p1_in_range_ff) upper_mem[ADDR_BITS'(p1_col_ff)] <= eff_mid;
   end

   always_ff @(posedge clock) begin
      if (req_fire && in_range) middle_rd_ff <= middle_mem[rd_addr];
      if (p1_valid_ff && p1_in_range_ff) middle_mem[ADDR_BITS'(p1_col_ff)] <= p1_pix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) p1_valid_ff <= 1'b0;
      else       p1_valid_ff <= req_fire;
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         p1_in_range_ff <= in_range;
         p1_out_en_ff   <= out_en;
         p1_fwd_ff      <= fwd_hit;
         p1_col_ff      <= cur_col;
         p1_pix_ff      <= req_data.pixel_in;
         p1_meta_ff     <= meta_in;
         fwd_top_ff     <= eff_mid;
         fwd_mid_ff     <= p1_pix_ff;
      end
   end

   // ---------------- window ----------------
   mf3_pkg::win_type window_ff, window_in;

   always_comb begin
      window_in    = window_ff;
      window_in[0] = window_ff[1];
      window_in[1] = window_ff[2];
      window_in[2] = eff_top;
      window_in[3] = window_ff[4];
      window_in[4] = window_ff[5];
      window_in[5] = eff_mid;
      window_in[6] = window_ff[7];
      window_in[7] = window_ff[8];
      window_in[8] = p1_pix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset)            window_ff <= '0;
      else if (p1_valid_ff) window_ff <= window_in;
   end

   // ---------------- median ----------------
   logic                   med_valid;
   mf3_pkg::pixel_type     med_value;
   mf3_pkg::meta_type      med_meta;
   mf3_pkg::med_status_type med_status;

   mf3_median u_median (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (p1_valid_ff && p1_out_en_ff),
      .in_window  (window_in),
      .in_meta    (p1_meta_ff),
      .out_valid  (med_valid),
      .out_median (med_value),
      .out_meta   (med_meta),
      .status     (med_status)
   );

   // ---------------- result queue ----------------
   localparam int PB = mf3_pkg::FIFO_PTR_BITS;
   localparam int NB = mf3_pkg::FIFO_COUNT_BITS;

   mf3_pkg::rsp_type fifo_mem [mf3_pkg::FIFO_DEPTH];
   mf3_pkg::rsp_type push_data;
   logic [PB-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [NB-1:0]    count_ff, count_in, pending;
   logic             pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = fifo_mem[rd_ptr_ff];

   always_comb begin
      push_data.median_value = med_value;
      push_data.centre_col   = med_meta.centre_col;
      push_data.centre_row   = med_meta.centre_row;
      push_data.frame_last   = med_meta.frame_last;
      count_in = count_ff + NB'(med_valid) - NB'(pop);
      pending  = count_ff + NB'(p1_valid_ff) + NB'(med_status.sort_busy)
                 + NB'(med_status.pick_busy);
   end

   // every accepted beat is reserved a queue slot
   assign req_ready = (pending < NB'(mf3_pkg::FIFO_DEPTH));

   always_ff @(posedge clock) begin
      if (med_valid) fifo_mem[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (med_valid) wr_ptr_ff <= wr_ptr_ff + PB'(1);
         if (pop)       rd_ptr_ff <= rd_ptr_ff + PB'(1);
         count_ff <= count_in;
      end
   end

endmodule

[src/mf3_checker.sv]
// ----------------------------------------------------------------------------
// mf3_checker
// Port-level checks for the streaming 3x3 median filter.
// ----------------------------------------------------------------------------
module mf3_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input mf3_pkg::rsp_type rsp_data
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   // reset empties the pipe and opens the input
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");

   // the centre is never on the top row or left column
   a_centre_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.centre_col != '0) && (rsp_data.centre_row != '0))
      else $error("centre on frame border");

   // the centre is never on the last possible column
   a_centre_col_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.centre_col != '1)
      else $error("centre column out of range");

endmodule

bind median_filter_3x3_stream mf3_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

[test/median_window_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// median_window_checker
// Follows the pixel stream into the 3x3 median filter, keeps its own copy of
// the line buffers, window, counters and geometry, predicts every median beat
// and compares each rsp beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module median_window_checker #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  mf3_pkg::req_type                     req_data,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  mf3_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [mf3_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [mf3_pkg::SIZE_BITS-1:0]        csr_wdata,
   output int                                   mismatch_count,
   output int                                   medians_owed
);

   localparam int          CB          = mf3_pkg::COORD_BITS;
   localparam int          TAPS        = mf3_pkg::WIN_TAPS;
   localparam int          WIDTH_LIMIT = (MAX_WIDTH < mf3_pkg::SIZE_CAP) ?
                                         MAX_WIDTH : mf3_pkg::SIZE_CAP;
   localparam int unsigned COORD_MASK  = (1 << CB) - 1;

   mf3_pkg::pixel_type upper_line [MAX_WIDTH];
   mf3_pkg::pixel_type middle_line [MAX_WIDTH];
   mf3_pkg::pixel_type taps [TAPS];
   int unsigned        col_next;
   int unsigned        row_next;
   int unsigned        width_cfg;
   int unsigned        height_cfg;
   mf3_pkg::rsp_type   medians_due [$];
   int                 fails;

   function automatic int unsigned clamp_size(input logic [mf3_pkg::SIZE_BITS-1:0] v,
                                              input int unsigned hi);
      if (v < mf3_pkg::MIN_SIZE)
         return 32'(mf3_pkg::MIN_SIZE);
      if (32'(v) > hi)
         return hi;
      return 32'(v);
   endfunction

   // plain insertion sort; the middle of nine is the median
   function automatic mf3_pkg::pixel_type window_median();
      mf3_pkg::pixel_type sorted [TAPS];
      mf3_pkg::pixel_type t;
      int                 j;
      for (int i = 0; i < TAPS; i++) begin
         t = taps[i];
         j = i;
         while (j > 0 && sorted[j-1] > t) begin
            sorted[j] = sorted[j-1];
            j--;
         end
         sorted[j] = t;
      end
      return sorted[TAPS / 2];
   endfunction

   task automatic take_pixel(input mf3_pkg::req_type beat);
      int unsigned        col;
      int unsigned        row;
      mf3_pkg::pixel_type top;
      mf3_pkg::pixel_type mid;
      logic               row_end;
      logic               frame_end;
      mf3_pkg::rsp_type   due;
      col = col_next;
      row = row_next;
      top = '0;
      mid = '0;
      if (beat.frame_start) begin
         col = 0;
         row = 0;
      end
      if (col < MAX_WIDTH) begin
         top = upper_line[col];
         mid = middle_line[col];
         upper_line[col]  = mid;
         middle_line[col] = beat.pixel_in;
      end
      for (int k = 0; k < 2; k++) begin
         taps[k]   = taps[k+1];
         taps[k+3] = taps[k+4];
         taps[k+6] = taps[k+7];
      end
      taps[2] = top;
      taps[5] = mid;
      taps[8] = beat.pixel_in;
      // a count at or past the last column / row closes it here
      row_end   = (col + 1 >= width_cfg);
      frame_end = row_end && (row + 1 >= height_cfg);
      if (row >= 2 && col >= 2) begin
         due.median_value = window_median();
         due.centre_col   = CB'((col - 1) & COORD_MASK);
         due.centre_row   = CB'((row - 1) & COORD_MASK);
         due.frame_last   = frame_end;
         medians_due.push_back(due);
      end
      if (row_end) begin
         col_next = 0;
         row_next = frame_end ? 0 : ((row + 1) & COORD_MASK);
      end else begin
         col_next = (col + 1) & COORD_MASK;
         row_next = row;
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      mf3_pkg::rsp_type due;
      if (reset) begin
         for (int i = 0; i < MAX_WIDTH; i++) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
         end
         for (int i = 0; i < TAPS; i++)
            taps[i] = '0;
         col_next   = 0;
         row_next   = 0;
         width_cfg  = 32'(mf3_pkg::RESET_WIDTH);
         height_cfg = 32'(mf3_pkg::RESET_HEIGHT);
         fails      = 0;
         medians_due.delete();
      end else begin
         // an rsp beat can never belong to a pixel taken at the same edge
         if (rsp_valid && rsp_ready) begin
            if (medians_due.size() == 0) begin
               $error("median beat with nothing expected: %0h", rsp_data);
               fails++;
            end else begin
               due = medians_due.pop_front();
               check_field("median_value", 32'(due.median_value),
                           32'(rsp_data.median_value));
               check_field("centre_col", 32'(due.centre_col), 32'(rsp_data.centre_col));
               check_field("centre_row", 32'(due.centre_row), 32'(rsp_data.centre_row));
               check_field("frame_last", 32'(due.frame_last), 32'(rsp_data.frame_last));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               mf3_pkg::CSR_FRAME_WIDTH:
                  width_cfg  = clamp_size(csr_wdata, WIDTH_LIMIT);
               mf3_pkg::CSR_FRAME_HEIGHT:
                  height_cfg = clamp_size(csr_wdata, 32'(mf3_pkg::HEIGHT_CAP));
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            take_pixel(req_data);
      end
      mismatch_count <= fails;
      medians_owed   <= medians_due.size();
   end

endmodule

[test/median_filter_3x3_stream_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// median_filter_3x3_stream_tb
// Drives pixel frames and geometry writes into the 3x3 median filter with
// random gaps and rsp back-pressure; the checker predicts and compares every
// median beat, and this top gives the verdict.
// ----------------------------------------------------------------------------
module median_filter_3x3_stream_tb;

   localparam int SB = mf3_pkg::SIZE_BITS;
   localparam int PB = mf3_pkg::PIXEL_BITS;
   localparam int XB = mf3_pkg::CSR_INDEX_BITS;

   localparam int                 CYCLE_LIMIT    = 200000;
   localparam int                 SETTLE_CYCLES  = 10;
   localparam int                 IDLE_PCT       = 15;
   localparam int                 RESTART_PCT    = 2;
   localparam int                 PHASES         = 8;
   localparam int                 PHASE_PIXELS   = 70;
   localparam int                 WIDE_COLS      = 64;
   localparam logic [XB-1:0]      CSR_UNMAPPED   = 4'd15;
   localparam logic [SB-1:0]      SIZE_FIELD_MAX = 11'h7ff;
   // zero, full scale, mid-scale and alternating bits
   localparam logic [9*PB-1:0]    EDGE_PIX = 72'h00_ff_80_7f_01_fe_55_aa_ff;

   logic                        clock     = 1'b0;
   logic                        reset     = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   mf3_pkg::req_type            req_data  = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   mf3_pkg::rsp_type            rsp_data;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [XB-1:0]               csr_index = '0;
   logic [SB-1:0]               csr_wdata = '0;
   logic                        gaps_on   = 1'b1;
   int                          mismatch_count;
   int                          medians_owed;
   int                          cycles    = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   median_filter_3x3_stream uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   median_window_checker window_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .medians_owed   (medians_owed)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
   end

   task automatic send_pixel(input mf3_pkg::pixel_type pix, input logic restart);
      while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{pixel_in: pix, frame_start: restart};
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // hold the sender until every median is back and the pipe has emptied
   task automatic wait_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (medians_owed != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [XB-1:0] idx,
                            input logic [SB-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int            i;
      int            ph;
      int            n;
      logic [SB-1:0] w;
      logic [SB-1:0] h;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset geometry: start row 0, then shrink the width under it
      for (i = 0; i < 4; i++)
         send_pixel(i[0] ? 8'h00 : 8'hff, i == 0);
      wait_quiet();
      write_csr(mf3_pkg::CSR_FRAME_WIDTH, 11'd0);
      write_csr(mf3_pkg::CSR_FRAME_HEIGHT, 11'd2);
      write_csr(CSR_UNMAPPED, SIZE_FIELD_MAX);
      // first beat closes row 0 past its last column, then rows 1 and 2
      for (i = 0; i < 7; i++)
         send_pixel(8'(i * 37), 1'b0);
      // restart twice, the second time mid-frame, with a clean 3x3 frame of extremes
      send_pixel(8'h00, 1'b1);
      send_pixel(8'hff, 1'b0);
      for (i = 0; i < 9; i++)
         send_pixel(EDGE_PIX[i*PB +: PB], i == 0);

      // a wider row: one full frame three rows high
      wait_quiet();
      write_csr(mf3_pkg::CSR_FRAME_WIDTH, SB'(WIDE_COLS));
      write_csr(mf3_pkg::CSR_FRAME_HEIGHT, 11'd0);
      for (i = 0; i < 3 * WIDE_COLS; i++)
         send_pixel(8'($urandom_range(255)), i == 0);

      // over-range sizes saturate; start a frame, then shrink both under it
      wait_quiet();
      write_csr(mf3_pkg::CSR_FRAME_WIDTH, SIZE_FIELD_MAX);
      write_csr(mf3_pkg::CSR_FRAME_HEIGHT, SIZE_FIELD_MAX);
      for (i = 0; i < 6; i++)
         send_pixel(8'($urandom_range(255)), i == 0);
      wait_quiet();
      write_csr(mf3_pkg::CSR_FRAME_WIDTH, 11'd4);
      for (i = 0; i < 1 + 4 * 5; i++)
         send_pixel(8'($urandom_range(255)), 1'b0);
      wait_quiet();
      write_csr(mf3_pkg::CSR_FRAME_HEIGHT, 11'd1);
      for (i = 0; i < 4; i++)
         send_pixel(8'($urandom_range(255)), 1'b0);

      // random frames at small sizes; width only grows at a frame start
      for (ph = 0; ph < PHASES; ph++) begin
         w = SB'($urandom_range(3, 12));
         h = SB'($urandom_range(3, 7));
         wait_quiet();
         write_csr(mf3_pkg::CSR_FRAME_WIDTH, (ph == 2) ? 11'd1 : w);
         write_csr(mf3_pkg::CSR_FRAME_HEIGHT, (ph == 5) ? 11'd2 : h);
         if (ph == 2)
            w = mf3_pkg::MIN_SIZE;
         gaps_on <= (ph != 3 && ph != 4);
         for (n = 0; n < PHASE_PIXELS; n++) begin
            if (n == PHASE_PIXELS / 2 && ph[0]) begin
               wait_quiet();
               // never wider mid-frame: every column read must have been written
               write_csr(mf3_pkg::CSR_FRAME_WIDTH, SB'($urandom_range(3, 32'(w))));
               write_csr(mf3_pkg::CSR_FRAME_HEIGHT, SB'($urandom_range(3, 7)));
            end
            send_pixel(8'($urandom_range(255)),
                       n == 0 || $urandom_range(99) < RESTART_PCT);
         end
      end

      wait_quiet();
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
